@@ hdl/bipd_pkg.sv @@
package bipd_pkg;

  localparam int unsigned GainW  = 8;
  localparam int unsigned TempW  = 10;
  localparam int unsigned ErrW   = 4;
  localparam int unsigned DriveW = 7;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 10;

  localparam logic [TempW-1:0]  BandLimit = TempW'(10);
  localparam logic [DriveW-1:0] DriveMax  = DriveW'(100);

  localparam logic [CfgIdxW-1:0] CfgPropGain  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgIntegGain = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgDerivGain = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgSetPoint  = 2'd3;

  localparam logic [GainW-1:0] PropGainRst  = 8'd5;
  localparam logic [GainW-1:0] IntegGainRst = 8'd2;
  localparam logic [GainW-1:0] DerivGainRst = 8'd0;
  localparam logic [TempW-1:0] SetPointRst  = 10'd26;

  typedef struct packed {
    logic [GainW-1:0] prop_gain;
    logic [GainW-1:0] integ_gain;
    logic [GainW-1:0] deriv_gain;
    logic [TempW-1:0] set_point;
  } cfg_t;

endpackage

@@ hdl/bipd_cfg.sv @@
module bipd_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bipd_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [bipd_pkg::CfgDataW-1:0]  cfg_wdata_i,
  output bipd_pkg::cfg_t                 cfg_o
);
  import bipd_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prop_gain  <= PropGainRst;
      cfg_q.integ_gain <= IntegGainRst;
      cfg_q.deriv_gain <= DerivGainRst;
      cfg_q.set_point  <= SetPointRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgPropGain:  cfg_q.prop_gain  <= cfg_wdata_i[GainW-1:0];
        CfgIntegGain: cfg_q.integ_gain <= cfg_wdata_i[GainW-1:0];
        CfgDerivGain: cfg_q.deriv_gain <= cfg_wdata_i[GainW-1:0];
        CfgSetPoint:  cfg_q.set_point  <= cfg_wdata_i[TempW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ hdl/bipd_step.sv @@
module bipd_step (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  bipd_pkg::cfg_t                cfg_i,
  input  logic [bipd_pkg::TempW-1:0]    meas_i,
  output logic [bipd_pkg::DriveW-1:0]   drive_d_o
);
  import bipd_pkg::*;

  logic [ErrW-1:0]   err_now_q, err_prev_q, err_prev2_q;
  logic [ErrW-1:0]   err_now_d, err_prev_d, err_prev2_d;
  logic [DriveW-1:0] drive_q, drive_d;

  logic              above;
  logic [TempW-1:0]  diff;
  logic [TempW-1:0]  err;
  logic [ErrW-1:0]   e0;
  logic [ErrW-1:0]   p_mag;
  logic              p_up;
  logic [ErrW:0]     twice, outer, d_mag;
  logic              d_up;
  logic [11:0]       p_prod, i_prod;
  logic [12:0]       d_prod;
  logic [13:0]       pos, neg, net;

  always_comb begin
    diff  = cfg_i.set_point - meas_i;
    above = cfg_i.set_point > meas_i;
    err   = diff;
    e0    = err[ErrW-1:0];

    p_up  = e0 > err_now_q;
    p_mag = p_up ? (e0 - err_now_q) : (err_now_q - e0);
    twice = {err_now_q, 1'b0};
    outer = {1'b0, e0} + {1'b0, err_prev_q};
    d_up  = outer > twice;
    d_mag = d_up ? (outer - twice) : (twice - outer);

    p_prod = {4'd0, cfg_i.prop_gain} * {8'd0, p_mag};
    i_prod = {4'd0, cfg_i.integ_gain} * {8'd0, e0};
    d_prod = {5'd0, cfg_i.deriv_gain} * {8'd0, d_mag};

    pos = {7'd0, drive_q} + {2'd0, i_prod}
        + (p_up ? {2'd0, p_prod} : 14'd0)
        + (d_up ? {1'b0, d_prod} : 14'd0);
    neg = (p_up ? 14'd0 : {2'd0, p_prod})
        + (d_up ? 14'd0 : {1'b0, d_prod});
    net = pos - neg;

    err_now_d   = err_now_q;
    err_prev_d  = err_prev_q;
    err_prev2_d = err_prev2_q;
    if (!above) begin
      drive_d = '0;
    end else if (err > BandLimit) begin
      drive_d = DriveMax;
    end else begin
      err_now_d   = e0;
      err_prev_d  = err_now_q;
      err_prev2_d = err_prev_q;
      if (pos <= neg) begin
        drive_d = '0;
      end else if (net < {7'd0, DriveMax}) begin
        drive_d = net[DriveW-1:0];
      end else begin
        drive_d = DriveMax;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_now_q   <= '0;
      err_prev_q  <= '0;
      err_prev2_q <= '0;
      drive_q     <= '0;
    end else if (en_i) begin
      err_now_q   <= err_now_d;
      err_prev_q  <= err_prev_d;
      err_prev2_q <= err_prev2_d;
      drive_q     <= drive_d;
    end
  end

  assign drive_d_o = drive_d;

endmodule

@@ hdl/banded_incremental_pid_drive.sv @@
// channel   signals                                      width
// in        in_valid_i, in_stall_o, measured_temp_i      10
// out       out_valid_o, out_stall_i, drive_percent_o    7
// cfg       cfg_we_i, cfg_idx_i, cfg_wdata_i             2 / 10
//
// one request per cycle sustained while out_stall_i is low; a taken request goes through the input
// register, then the pid update into the result register
// reset clears the error history, the drive level and both valid flags; gains and set point
// return to their defaults
// a stalled output holds the input register full, and in_stall_o follows out_stall_i then
module banded_incremental_pid_drive (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [bipd_pkg::TempW-1:0]    measured_temp_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [bipd_pkg::DriveW-1:0]   drive_percent_o,
  input  logic                          cfg_we_i,
  input  logic [bipd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [bipd_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import bipd_pkg::*;

  cfg_t              cfg;
  logic              in_valid_q, out_valid_q;
  logic [TempW-1:0]  meas_q;
  logic [DriveW-1:0] drive_q, drive_d;
  logic              advance, take;

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign take       = in_valid_i && !in_stall_o;

  bipd_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  bipd_step u_step (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (advance),
    .cfg_i     (cfg),
    .meas_i    (meas_q),
    .drive_d_o (drive_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      meas_q <= measured_temp_i;
    end
    if (advance) begin
      drive_q <= drive_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign drive_percent_o = drive_q;

endmodule

@@ tb/tb.sv @@
module tb;
  import bipd_pkg::*;

  localparam int NumPhases     = 8;
  localparam int ItemsPerPhase = 205;
  localparam int SettleCycles  = 4;
  localparam int LongHold      = 80;

  typedef enum logic {RowTemp, RowReg} row_kind_e;

  typedef struct packed {
    row_kind_e           kind;
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] value;
    int                  want;
  } row_t;

  // want of -1: take the drive from the predictor
  localparam row_t Plan [28] = '{
    '{RowTemp, '0, 10'd26, 0},
    '{RowTemp, '0, 10'd1023, 0},
    '{RowTemp, '0, 10'd0, 100},
    '{RowTemp, '0, 10'd15, 100},
    '{RowTemp, '0, 10'd16, -1},
    '{RowTemp, '0, 10'd25, -1},
    '{RowTemp, '0, 10'd25, -1},
    '{RowTemp, '0, 10'd26, 0},
    '{RowTemp, '0, 10'd16, -1},
    '{RowReg, CfgPropGain, 10'h3FF, -1},
    '{RowReg, CfgIntegGain, 10'd0, -1},
    '{RowReg, CfgDerivGain, 10'h3FF, -1},
    '{RowTemp, '0, 10'd25, -1},
    '{RowTemp, '0, 10'd16, -1},
    '{RowReg, CfgSetPoint, 10'd0, -1},
    '{RowTemp, '0, 10'd0, 0},
    '{RowTemp, '0, 10'd1023, 0},
    '{RowReg, CfgSetPoint, 10'd1023, -1},
    '{RowTemp, '0, 10'd0, 100},
    '{RowTemp, '0, 10'd1013, -1},
    '{RowTemp, '0, 10'd1022, -1},
    '{RowReg, CfgPropGain, 10'd0, -1},
    '{RowReg, CfgIntegGain, 10'd255, -1},
    '{RowReg, CfgDerivGain, 10'd0, -1},
    '{RowTemp, '0, 10'd1022, -1},
    '{RowReg, CfgIntegGain, 10'd0, -1},
    '{RowTemp, '0, 10'd1022, -1},
    '{RowTemp, '0, 10'd1013, -1}
  };

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [TempW-1:0]    measured_temp_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [DriveW-1:0]   drive_percent_o;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  logic [GainW-1:0]  prop_gain;
  logic [GainW-1:0]  integ_gain;
  logic [GainW-1:0]  deriv_gain;
  logic [TempW-1:0]  set_point;
  logic [ErrW-1:0]   err_now;
  logic [ErrW-1:0]   err_prev;
  logic [ErrW-1:0]   err_prev2;
  logic [DriveW-1:0] drive_level;

  logic [DriveW-1:0] pending_drive [$];
  int                errs;
  int                row_want;
  bit                calm;
  bit                long_hold;

  banded_incremental_pid_drive dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .measured_temp_i(measured_temp_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .drive_percent_o(drive_percent_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic logic [DriveW-1:0] pid_step(logic [TempW-1:0] temp);
    int err;
    int pos;
    int neg;
    int twice;
    int outer;
    pos = 0;
    neg = 0;
    if (set_point > temp) begin
      err = int'(set_point) - int'(temp);
      if (err > int'(BandLimit)) begin
        drive_level = DriveMax;
      end else begin
        err_prev2 = err_prev;
        err_prev  = err_now;
        err_now   = ErrW'(err);
        if (err_now > err_prev) begin
          pos += int'(prop_gain) * (int'(err_now) - int'(err_prev));
        end else begin
          neg += int'(prop_gain) * (int'(err_prev) - int'(err_now));
        end
        pos += int'(integ_gain) * int'(err_now);
        twice = 2 * int'(err_prev);
        outer = int'(err_now) + int'(err_prev2);
        if (outer > twice) begin
          pos += int'(deriv_gain) * (outer - twice);
        end else begin
          neg += int'(deriv_gain) * (twice - outer);
        end
        pos += int'(drive_level);
        if (pos > neg) begin
          drive_level = (pos - neg < int'(DriveMax)) ? DriveW'(pos - neg) : DriveMax;
        end else begin
          drive_level = '0;
        end
      end
    end else begin
      drive_level = '0;
    end
    return drive_level;
  endfunction

  // mostly inside the band, some at or above set point, some past the band
  function automatic logic [TempW-1:0] pick_temp();
    int t;
    case ($urandom_range(0, 9))
      0: begin
        t = int'($urandom_range(0, 1023));
      end
      1: begin
        t = int'(set_point) + int'($urandom_range(0, 3));
      end
      2: begin
        t = int'(set_point) - int'($urandom_range(11, 20));
      end
      default: begin
        t = int'(set_point) - int'($urandom_range(1, 10));
      end
    endcase
    if (t < 0) t = 0;
    if (t > 1023) t = 1023;
    return TempW'(t);
  endfunction

  function automatic logic [CfgDataW-1:0] pick_gain();
    logic [GainW-1:0] g;
    g = ($urandom_range(0, 3) == 0) ? GainW'($urandom_range(0, 255))
                                    : GainW'($urandom_range(0, 12));
    return {2'($urandom_range(0, 3)), g};
  endfunction

  always @(posedge clk_i) begin : scoreboard
    logic [DriveW-1:0] want;
    logic [DriveW-1:0] got;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_drive.size() == 0) begin
          $error("drive_percent: unexpected result %0d", drive_percent_o);
          errs++;
        end else begin
          want = pending_drive.pop_front();
          if (drive_percent_o !== want) begin
            $error("drive_percent: expected %0d, got %0d", want, drive_percent_o);
            errs++;
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        got = pid_step(measured_temp_i);
        pending_drive.push_back(row_want >= 0 ? DriveW'(row_want) : got);
      end
    end
  end

  // output stall in bursts, one long hold on request
  initial begin
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (long_hold) begin
        out_stall_i <= 1'b1;
        repeat (LongHold) @(negedge clk_i);
        long_hold = 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 15)) @(negedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk_i);
      end
    end
  end

  task automatic send_temp(input logic [TempW-1:0] temp, input int want);
    int gap;
    gap = 0;
    if (!calm && !long_hold && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 15);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    measured_temp_i <= temp;
    row_want = want;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_drive.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      CfgPropGain:  prop_gain  = val[GainW-1:0];
      CfgIntegGain: integ_gain = val[GainW-1:0];
      CfgDerivGain: deriv_gain = val[GainW-1:0];
      CfgSetPoint:  set_point  = val[TempW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin : stimulus
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    measured_temp_i = '0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = '0;
    cfg_wdata_i     = '0;
    errs            = 0;
    row_want        = -1;
    calm            = 1'b0;
    long_hold       = 1'b0;
    prop_gain       = PropGainRst;
    integ_gain      = IntegGainRst;
    deriv_gain      = DerivGainRst;
    set_point       = SetPointRst;
    err_now         = '0;
    err_prev        = '0;
    err_prev2       = '0;
    drive_level     = '0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < $size(Plan); i++) begin
      if (Plan[i].kind == RowReg) begin
        drain();
        write_reg(Plan[i].idx, Plan[i].value);
      end else begin
        send_temp(Plan[i].value, Plan[i].want);
      end
    end

    for (int p = 0; p < NumPhases; p++) begin
      drain();
      if (p == 0) begin
        write_reg(CfgPropGain, 10'd255);
        write_reg(CfgIntegGain, 10'd255);
        write_reg(CfgDerivGain, 10'd255);
        write_reg(CfgSetPoint, 10'd1023);
      end else if (p == 1) begin
        write_reg(CfgPropGain, 10'd0);
        write_reg(CfgIntegGain, 10'd0);
        write_reg(CfgDerivGain, 10'd0);
        write_reg(CfgSetPoint, 10'd11);
      end else begin
        write_reg(CfgPropGain, pick_gain());
        write_reg(CfgIntegGain, pick_gain());
        write_reg(CfgDerivGain, pick_gain());
        write_reg(CfgSetPoint, CfgDataW'($urandom_range(0, 1023)));
      end
      // fill the pipe against a held output
      if (p == 2) long_hold = 1'b1;
      if (p == NumPhases - 1) calm = 1'b1;
      for (int n = 0; n < ItemsPerPhase; n++) send_temp(pick_temp(), -1);
    end

    drain();
    if (errs == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
